// ===== design/go_to_goal_wheel_speeds_unit_defines.svh =====
// Assertion macros shared by the go-to-goal wheel speed unit.
`ifndef GO_TO_GOAL_WHEEL_SPEEDS_UNIT_DEFINES_SVH
`define GO_TO_GOAL_WHEEL_SPEEDS_UNIT_DEFINES_SVH
`ifndef ASSERT_OFF
// Checked property that is ignored while reset is asserted.
`define GGWS_ASSERT(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Checked property that also holds during reset.
`define GGWS_ASSERT_ALWAYS(name, clk, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);
`else
`define GGWS_ASSERT(name, clk, rst_n, prop, msg)
`define GGWS_ASSERT_ALWAYS(name, clk, prop, msg)
`endif
`endif

// ===== design/ggws_pkg.sv =====
// Constants, register codes and CORDIC tables of the go-to-goal wheel speed unit.
`default_nettype none
package ggws_pkg;

  localparam int unsigned FRAC_BITS    = 12;
  localparam int unsigned ANG_SHIFT    = 30 - FRAC_BITS;
  localparam int unsigned CORDIC_STEPS = 28;

  localparam longint PI_Q30          = 64'sd3373259426;
  localparam longint HALF_PI_Q30     = 64'sd1686629713;
  localparam longint CORDIC_GAIN_Q30 = 64'sd652032874;
  localparam longint PI_F     = (PI_Q30 + (64'sd1 <<< (ANG_SHIFT - 1))) >>> ANG_SHIFT;
  localparam longint TWO_PI_F = 2 * PI_F;

  // Register indexes of the configuration port.
  localparam logic [2:0] REG_TURN_GAIN    = 3'd0;
  localparam logic [2:0] REG_SPEED_GAIN   = 3'd1;
  localparam logic [2:0] REG_TURN_LIMIT   = 3'd2;
  localparam logic [2:0] REG_SPEED_LIMIT  = 3'd3;
  localparam logic [2:0] REG_ARRIVE_TOL   = 3'd4;
  localparam logic [2:0] REG_ROBOT_RADIUS = 3'd5;

  // atan(2^-i) in Q30.
  localparam logic [29:0] ATAN_Q30 [CORDIC_STEPS] = '{
    30'd843314856, 30'd497837829, 30'd263043836, 30'd133525158, 30'd67021686,
    30'd33543515, 30'd16775850, 30'd8388437, 30'd4194282, 30'd2097149,
    30'd1048575, 30'd524287, 30'd262143, 30'd131071, 30'd65535, 30'd32767,
    30'd16383, 30'd8191, 30'd4095, 30'd2047, 30'd1023, 30'd511, 30'd255,
    30'd127, 30'd63, 30'd31, 30'd15, 30'd8
  };

endpackage
`default_nettype wire

// ===== design/ggws_delay.sv =====
// Enabled shift line that keeps side data aligned with the pipeline.
`default_nettype none
module ggws_delay #(
  parameter int unsigned WIDTH = 1,
  parameter int unsigned DEPTH = 1
) (
  input  wire logic             clk_i,
  input  wire logic             en_i,
  input  wire logic [WIDTH-1:0] d_i,
  output logic      [WIDTH-1:0] q_o
);

  logic [WIDTH-1:0] sr_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sr_q[0] <= d_i;
      for (int i = 1; i < DEPTH; i++) begin
        sr_q[i] <= sr_q[i-1];
      end
    end
  end

  assign q_o = sr_q[DEPTH-1];

endmodule
`default_nettype wire

// ===== design/ggws_isqrt.sv =====
// Pipelined distance unit: squares, sum and one root bit per stage.
`default_nettype none
module ggws_isqrt (
  input  wire logic               clk_i,
  input  wire logic               en_i,
  input  wire logic signed [16:0] dx_i,
  input  wire logic signed [16:0] dy_i,
  output logic             [16:0] d_o
);

  localparam int unsigned STEPS = 17;

  logic signed [33:0] sqx_d, sqy_d;
  logic [33:0] sqx_q, sqy_q;
  logic [33:0] n_q [STEPS+1];
  logic [33:0] r_q [STEPS+1];

  assign sqx_d = dx_i * dx_i;
  assign sqy_d = dy_i * dy_i;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sqx_q  <= sqx_d;
      sqy_q  <= sqy_d;
      n_q[0] <= sqx_q + sqy_q;
      r_q[0] <= '0;
    end
  end

  for (genvar k = 0; k < STEPS; k++) begin : g_step
    localparam logic [33:0] BIT = 34'd1 << (2 * (STEPS - 1 - k));
    logic [33:0] trial;
    assign trial = r_q[k] + BIT;
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (n_q[k] >= trial) begin
          n_q[k+1] <= n_q[k] - trial;
          r_q[k+1] <= (r_q[k] >> 1) + BIT;
        end else begin
          n_q[k+1] <= n_q[k];
          r_q[k+1] <= r_q[k] >> 1;
        end
      end
    end
  end

  assign d_o = r_q[STEPS][16:0];

endmodule
`default_nettype wire

// ===== design/ggws_cordic_vec.sv =====
// Pipelined CORDIC in vectoring mode that gives the bearing in Q30.
`default_nettype none
module ggws_cordic_vec (
  input  wire logic               clk_i,
  input  wire logic               en_i,
  input  wire logic signed [16:0] dx_i,
  input  wire logic signed [16:0] dy_i,
  output logic signed      [35:0] z_o
);

  localparam int unsigned N = ggws_pkg::CORDIC_STEPS;

  logic signed [33:0] x0, y0;
  logic signed [33:0] x_q [N+1];
  logic signed [33:0] y_q [N+1];
  logic signed [35:0] z_q [N+1];

  assign x0 = $signed({{3{dx_i[16]}}, dx_i, 14'b0});
  assign y0 = $signed({{3{dy_i[16]}}, dy_i, 14'b0});

  // Left half plane: turn the vector by pi and start the angle there.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (dx_i[16]) begin
        x_q[0] <= -x0;
        y_q[0] <= -y0;
        z_q[0] <= dy_i[16] ? -36'(ggws_pkg::PI_Q30) : 36'(ggws_pkg::PI_Q30);
      end else begin
        x_q[0] <= x0;
        y_q[0] <= y0;
        z_q[0] <= '0;
      end
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_iter
    localparam logic signed [35:0] ATAN = $signed({6'b0, ggws_pkg::ATAN_Q30[i]});
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (!y_q[i][33]) begin
          x_q[i+1] <= x_q[i] + (y_q[i] >>> i);
          y_q[i+1] <= y_q[i] - (x_q[i] >>> i);
          z_q[i+1] <= z_q[i] + ATAN;
        end else begin
          x_q[i+1] <= x_q[i] - (y_q[i] >>> i);
          y_q[i+1] <= y_q[i] + (x_q[i] >>> i);
          z_q[i+1] <= z_q[i] - ATAN;
        end
      end
    end
  end

  assign z_o = z_q[N];

endmodule
`default_nettype wire

// ===== design/ggws_cordic_rot.sv =====
// Pipelined CORDIC in rotation mode that gives the cosine of the heading error.
`default_nettype none
module ggws_cordic_rot (
  input  wire logic               clk_i,
  input  wire logic               en_i,
  input  wire logic signed [15:0] e_i,
  output logic signed      [15:0] cos_o
);

  localparam int unsigned N = ggws_pkg::CORDIC_STEPS;
  localparam int unsigned S = ggws_pkg::ANG_SHIFT;
  localparam logic signed [35:0] PI   = 36'(ggws_pkg::PI_Q30);
  localparam logic signed [35:0] HALF = 36'(ggws_pkg::HALF_PI_Q30);
  localparam logic signed [33:0] RND  = 34'sd1 <<< (S - 1);

  logic signed [35:0] z0;
  logic signed [33:0] x_q [N+1];
  logic signed [33:0] y_q [N+1];
  logic signed [35:0] z_q [N+1];
  logic               neg_q [N+1];
  logic signed [33:0] xr;
  logic signed [15:0] cos_q;

  assign z0 = 36'(e_i) <<< S;

  // Angles beyond a quarter turn are folded by pi and the result negated.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q[0] <= 34'(ggws_pkg::CORDIC_GAIN_Q30);
      y_q[0] <= '0;
      if (z0 > HALF) begin
        z_q[0]   <= z0 - PI;
        neg_q[0] <= 1'b1;
      end else if (z0 < -HALF) begin
        z_q[0]   <= z0 + PI;
        neg_q[0] <= 1'b1;
      end else begin
        z_q[0]   <= z0;
        neg_q[0] <= 1'b0;
      end
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_iter
    localparam logic signed [35:0] ATAN = $signed({6'b0, ggws_pkg::ATAN_Q30[i]});
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        neg_q[i+1] <= neg_q[i];
        if (!z_q[i][35]) begin
          x_q[i+1] <= x_q[i] - (y_q[i] >>> i);
          y_q[i+1] <= y_q[i] + (x_q[i] >>> i);
          z_q[i+1] <= z_q[i] - ATAN;
        end else begin
          x_q[i+1] <= x_q[i] + (y_q[i] >>> i);
          y_q[i+1] <= y_q[i] - (x_q[i] >>> i);
          z_q[i+1] <= z_q[i] + ATAN;
        end
      end
    end
  end

  assign xr = (x_q[N] + RND) >>> S;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cos_q <= neg_q[N] ? -xr[15:0] : xr[15:0];
    end
  end

  assign cos_o = cos_q;

endmodule
`default_nettype wire

// ===== design/go_to_goal_wheel_speeds_unit.sv =====
// Top level of the go-to-goal wheel speed unit for a differential drive.
//
// The input stream carries one beat per control update: target point and
// robot position in signed Q4.12, heading in signed Q3.12. The output stream
// returns one beat per input beat with the right and left wheel speeds in
// tdata and the arrived flag in tuser. Gains, limits, arrive tolerance and
// robot radius are written through the configuration channel, which is always
// ready; writes are meant to happen only while the unit holds no work.
//
// The datapath is a 65 stage pipeline: distance root, bearing CORDIC and
// cosine CORDIC take one step per stage, and a new beat can be accepted every
// cycle while no result waits untaken at the output.
// Reset clears every valid bit and loads the register defaults.
// When the receiver stalls with a result waiting, the whole pipeline holds
// and the input side is not ready until the result is taken; a valid bit
// travels with every stage so bubbles never produce output beats.
`default_nettype none
`include "go_to_goal_wheel_speeds_unit_defines.svh"
module go_to_goal_wheel_speeds_unit (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  // target_x [15:0], target_y [31:16], current_x [47:32], current_y [63:48],
  // current_heading [78:64], zero [79]
  input  wire logic [79:0] s_axis_tdata_i,
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  // right_speed [15:0], left_speed [31:16]
  output logic      [31:0] m_axis_tdata_o,
  // arrived [0]
  output logic             m_axis_tuser_o,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [2:0]  cfg_index_i,
  input  wire logic [15:0] cfg_data_i
);

  localparam int unsigned LAST = 64;
  localparam int unsigned F    = ggws_pkg::FRAC_BITS;
  localparam int unsigned S    = ggws_pkg::ANG_SHIFT;

  // Configuration registers.
  logic [14:0] turn_gain_q, speed_gain_q, turn_limit_q, speed_limit_q, arrive_tol_q;
  logic [12:0] radius_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      turn_gain_q   <= 15'd4915;
      speed_gain_q  <= 15'd4096;
      turn_limit_q  <= 15'd12288;
      speed_limit_q <= 15'd2458;
      arrive_tol_q  <= 15'd287;
      radius_q      <= 13'd410;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        ggws_pkg::REG_TURN_GAIN:    turn_gain_q   <= cfg_data_i[14:0];
        ggws_pkg::REG_SPEED_GAIN:   speed_gain_q  <= cfg_data_i[14:0];
        ggws_pkg::REG_TURN_LIMIT:   turn_limit_q  <= cfg_data_i[14:0];
        ggws_pkg::REG_SPEED_LIMIT:  speed_limit_q <= cfg_data_i[14:0];
        ggws_pkg::REG_ARRIVE_TOL:   arrive_tol_q  <= cfg_data_i[14:0];
        ggws_pkg::REG_ROBOT_RADIUS: radius_q      <= cfg_data_i[12:0];
        default: ;
      endcase
    end
  end

  // Whole-pipeline advance: everything moves unless a result waits untaken.
  logic        en;
  logic [LAST:0] vld_q;

  assign en = !vld_q[LAST] || m_axis_tready_i;
  assign s_axis_tready_o = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[LAST-1:0], s_axis_tvalid_i};
    end
  end

  // Stage 0: position differences and heading.
  logic signed [16:0] dx_q, dy_q;
  logic signed [14:0] hd_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      dx_q <= 17'($signed(s_axis_tdata_i[15:0])) - 17'($signed(s_axis_tdata_i[47:32]));
      dy_q <= 17'($signed(s_axis_tdata_i[31:16])) - 17'($signed(s_axis_tdata_i[63:48]));
      hd_q <= s_axis_tdata_i[78:64];
    end
  end

  // Distance comes out at stage 19, bearing at stage 29.
  logic        [16:0] distance;
  logic signed [35:0] bearing_z;

  ggws_isqrt u_isqrt (
    .clk_i (clk_i),
    .en_i  (en),
    .dx_i  (dx_q),
    .dy_i  (dy_q),
    .d_o   (distance)
  );

  ggws_cordic_vec u_vec (
    .clk_i (clk_i),
    .en_i  (en),
    .dx_i  (dx_q),
    .dy_i  (dy_q),
    .z_o   (bearing_z)
  );

  // Stage 20: arrival test and speed gain times distance.
  logic        arr_q;
  logic [31:0] sgd_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      arr_q <= {15'b0, distance} <= {17'b0, arrive_tol_q};
      sgd_q <= 32'(distance) * 32'(speed_gain_q);
    end
  end

  logic [14:0] hd_dly;

  ggws_delay #(.WIDTH(15), .DEPTH(29)) u_hd_dly (
    .clk_i (clk_i),
    .en_i  (en),
    .d_i   (hd_q),
    .q_o   (hd_dly)
  );

  // Stage 30: rounded bearing minus heading, offset by pi.
  logic signed [35:0] z_rnd;
  logic signed [19:0] t_q;

  assign z_rnd = (bearing_z + (36'sd1 <<< (S - 1))) >>> S;

  always_ff @(posedge clk_i) begin
    if (en) begin
      t_q <= z_rnd[19:0] - 20'($signed(hd_dly)) + 20'(ggws_pkg::PI_F);
    end
  end

  // Stage 31: wrap into [-pi, pi). One correction suffices for the range
  // of bearing and heading.
  logic signed [19:0] t_wrap;
  logic signed [15:0] e_q;

  always_comb begin
    if (t_q[19]) begin
      t_wrap = t_q + 20'(ggws_pkg::TWO_PI_F);
    end else if (t_q >= 20'(ggws_pkg::TWO_PI_F)) begin
      t_wrap = t_q - 20'(ggws_pkg::TWO_PI_F);
    end else begin
      t_wrap = t_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      e_q <= 16'(t_wrap - 20'(ggws_pkg::PI_F));
    end
  end

  // Turn path, stages 32 to 35.
  logic signed [31:0] pw_q, pw_rnd;
  logic signed [15:0] w_q;
  logic signed [29:0] prw_q, prw_rnd;
  logic signed [17:0] rw_q;
  logic signed [15:0] tlim;

  assign tlim    = $signed({1'b0, turn_limit_q});
  assign pw_rnd  = (pw_q + (32'sd1 <<< (F - 1))) >>> F;
  assign prw_rnd = (prw_q + (30'sd1 <<< (F - 1))) >>> F;

  always_ff @(posedge clk_i) begin
    if (en) begin
      pw_q <= $signed({1'b0, turn_gain_q}) * e_q;
      if (pw_rnd > 32'(tlim)) begin
        w_q <= tlim;
      end else if (pw_rnd < -32'(tlim)) begin
        w_q <= -tlim;
      end else begin
        w_q <= pw_rnd[15:0];
      end
      prw_q <= $signed({1'b0, radius_q}) * w_q;
      rw_q  <= prw_rnd[17:0];
    end
  end

  // Cosine of the error is ready at stage 61.
  logic signed [15:0] cos_e;

  ggws_cordic_rot u_rot (
    .clk_i (clk_i),
    .en_i  (en),
    .e_i   (e_q),
    .cos_o (cos_e)
  );

  logic [32:0] as_dly;
  logic [17:0] rw_dly;

  ggws_delay #(.WIDTH(33), .DEPTH(41)) u_as_dly (
    .clk_i (clk_i),
    .en_i  (en),
    .d_i   ({arr_q, sgd_q}),
    .q_o   (as_dly)
  );

  ggws_delay #(.WIDTH(18), .DEPTH(28)) u_rw_dly (
    .clk_i (clk_i),
    .en_i  (en),
    .d_i   (rw_q),
    .q_o   (rw_dly)
  );

  // Stages 62 and 63: forward speed product, rounding and clamp.
  logic signed [48:0] p_q, p_rnd;
  logic               arr_p_q, arr_v_q;
  logic signed [15:0] v_q;
  logic signed [15:0] slim;

  assign slim  = $signed({1'b0, speed_limit_q});
  assign p_rnd = (p_q + (49'sd1 <<< (2 * F - 1))) >>> (2 * F);

  always_ff @(posedge clk_i) begin
    if (en) begin
      p_q     <= $signed({1'b0, as_dly[31:0]}) * cos_e;
      arr_p_q <= as_dly[32];
      if (p_rnd > 49'(slim)) begin
        v_q <= slim;
      end else if (p_rnd < -49'(slim)) begin
        v_q <= -slim;
      end else begin
        v_q <= p_rnd[15:0];
      end
      arr_v_q <= arr_p_q;
    end
  end

  // Stage 64: wheel mixing with saturation into the output register; arrived beats give zero speeds.
  logic signed [18:0] sum_r, sum_l;
  logic signed [15:0] right_q, left_q;
  logic               arrived_q;

  assign sum_r = 19'(v_q) + 19'($signed(rw_dly));
  assign sum_l = 19'(v_q) - 19'($signed(rw_dly));

  function automatic logic signed [15:0] sat16(input logic signed [18:0] v);
    if (v > 19'sd32767) begin
      sat16 = 16'sh7FFF;
    end else if (v < -19'sd32768) begin
      sat16 = 16'sh8000;
    end else begin
      sat16 = v[15:0];
    end
  endfunction

  always_ff @(posedge clk_i) begin
    if (en) begin
      arrived_q <= arr_v_q;
      right_q   <= arr_v_q ? '0 : sat16(sum_r);
      left_q    <= arr_v_q ? '0 : sat16(sum_l);
    end
  end

  assign m_axis_tvalid_o = vld_q[LAST];
  assign m_axis_tdata_o  = {left_q, right_q};
  assign m_axis_tuser_o  = arrived_q;

  `GGWS_ASSERT(a_arrived_stops, clk_i, rst_ni, m_axis_tvalid_o && m_axis_tuser_o |-> m_axis_tdata_o == 32'd0, "arrived beat with nonzero speed")
  `GGWS_ASSERT(a_stall_holds, clk_i, rst_ni, m_axis_tvalid_o && !m_axis_tready_i |=> $stable(vld_q), "pipeline moved during stall")
  `GGWS_ASSERT(a_speed_clamped, clk_i, rst_ni, vld_q[LAST-1] |-> v_q <= slim && v_q >= -slim, "forward speed beyond limit")
  `GGWS_ASSERT_ALWAYS(a_ready_when_empty, clk_i, !m_axis_tvalid_o |-> s_axis_tready_o, "input blocked with empty output")

endmodule
`default_nettype wire
